// ===== hw/rtl/ibusrc_pkg.sv =====
// shared constants and types for the rc serial frame decoder
package ibusrc_pkg;

	localparam int FRAME_BYTES = 32;
	localparam int CNT_W       = $clog2(FRAME_BYTES);

	localparam logic [7:0]  HDR0        = 8'h20;
	localparam logic [7:0]  HDR1        = 8'h40;
	localparam logic [15:0] SUM_INIT    = 16'hFFFF;
	localparam logic [15:0] CENTER_RAW  = 16'd1000;
	localparam logic [15:0] FULL_TENTHS = 16'd1000;
	localparam logic [15:0] MS_MAX      = 16'hFFFF;

	localparam logic [CNT_W-1:0] IDX_HDR1 = CNT_W'(1);
	localparam logic [CNT_W-1:0] IDX_DATA = CNT_W'(2);
	localparam logic [CNT_W-1:0] IDX_CHK  = CNT_W'(FRAME_BYTES - 2);
	localparam logic [CNT_W-1:0] IDX_LAST = CNT_W'(FRAME_BYTES - 1);

	localparam logic [1:0] REQ_BYTE = 2'd0;
	localparam logic [1:0] REQ_IDLE = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic KIND_CHAN = 1'b0;
	localparam logic KIND_LINK = 1'b1;

	localparam logic [1:0] REG_TIMEOUT   = 2'd0;
	localparam logic [1:0] REG_VALID_MIN = 2'd1;
	localparam logic [1:0] REG_VALID_MAX = 2'd2;

	localparam logic [15:0] TIMEOUT_RST   = 16'd100;
	localparam logic [15:0] VALID_MIN_RST = 16'd800;
	localparam logic [15:0] VALID_MAX_RST = 16'd2200;

	typedef struct packed {
		logic        kind;
		logic [3:0]  channel;
		logic [15:0] raw_value;
		logic [9:0]  position_tenths;
		logic        in_range;
		logic        link_ok;
		logic        last;
	} res_t;

endpackage

// ===== hw/rtl/ibusrc_if.sv =====
// handshake channels for requests, results and register writes
interface ibusrc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] data_byte;
	modport source (output valid, req_type, data_byte, input ready);
	modport sink (input valid, req_type, data_byte, output ready);
endinterface

interface ibusrc_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [3:0]  channel;
	logic [15:0] raw_value;
	logic [9:0]  position_tenths;
	logic        in_range;
	logic        link_ok;
	logic        last;
	modport source (output valid, kind, channel, raw_value, position_tenths, in_range,
		link_ok, last, input ready);
	modport sink (input valid, kind, channel, raw_value, position_tenths, in_range,
		link_ok, last, output ready);
endinterface

interface ibusrc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ibus_rc_frame_decoder_top.sv =====
// rc serial frame decoder: framing, channel window/clamp sequencer, link status
// a tick result is registered and shows in the cycle after the tick is taken
// a frame-closing byte with a good header and checksum starts a burst of NUM_CHANNELS results, one per
// cycle while not stalled, through the shared window compare and clamp; no request is taken until the burst has left
// requests are taken only while the result register is free or being drained
// reset: registers to 100/800/2200, positions zero, link unseen, no frame in progress
module ibus_rc_frame_decoder_top #(
	parameter int NUM_CHANNELS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ibusrc_req_if.sink           req,
	ibusrc_res_if.source         res,
	ibusrc_cfg_if.sink           cfg
);
	import ibusrc_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_BURST = 1'b1;

	logic             state_q;
	logic [CH_W-1:0]  ch_q;
	logic [15:0]      timeout_q;
	logic [15:0]      vmin_q;
	logic [15:0]      vmax_q;
	logic             seen_q;
	logic [15:0]      ms_q;
	logic [9:0]       pos_q [NUM_CHANNELS];
	logic             res_valid_q;
	res_t             res_q;

	logic             out_free;
	logic             accept;
	logic             byte_en;
	logic             idle_en;
	logic             tick_en;
	logic             frame_ok;
	logic [15:0]      rd_word;
	logic [15:0]      ms_next;
	logic             burst_go;
	logic             inr;
	logic [16:0]      diff;
	logic [9:0]       pos_new;
	logic [9:0]       pos_out;

	ibusrc_frame_rx #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.CH_W(CH_W)
	) u_frame_rx (
		.clk(clk),
		.arst_n(arst_n),
		.byte_en(byte_en),
		.idle_en(idle_en),
		.data_byte(req.data_byte),
		.rd_idx(ch_q),
		.frame_ok(frame_ok),
		.rd_word(rd_word)
	);

	assign out_free  = !res_valid_q || res.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign byte_en   = accept && (req.req_type == REQ_BYTE);
	assign idle_en   = accept && (req.req_type == REQ_IDLE);
	assign tick_en   = accept && (req.req_type == REQ_TICK);
	assign ms_next   = (ms_q == MS_MAX) ? ms_q : ms_q + 16'd1;
	assign burst_go  = (state_q == ST_BURST) && out_free;

	// shared window compare and clamp for the channel in turn
	always_comb begin
		inr  = (rd_word >= vmin_q) && (rd_word <= vmax_q);
		diff = {1'b0, rd_word} - {1'b0, CENTER_RAW};
		if (diff[16]) begin
			pos_new = '0;
		end else if (diff[15:0] > FULL_TENTHS) begin
			pos_new = FULL_TENTHS[9:0];
		end else begin
			pos_new = diff[9:0];
		end
		pos_out = inr ? pos_new : pos_q[ch_q];
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			vmin_q    <= VALID_MIN_RST;
			vmax_q    <= VALID_MAX_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TIMEOUT:   timeout_q <= cfg.data;
				REG_VALID_MIN: vmin_q    <= cfg.data;
				REG_VALID_MAX: vmax_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			seen_q  <= 1'b0;
			ms_q    <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				pos_q[i] <= '0;
			end
		end else begin
			if (tick_en) begin
				ms_q <= ms_next;
			end
			if (frame_ok) begin
				seen_q  <= 1'b1;
				ms_q    <= '0;
				ch_q    <= '0;
				state_q <= ST_BURST;
			end
			if (burst_go) begin
				if (inr) begin
					pos_q[ch_q] <= pos_new;
				end
				if (ch_q == CH_LAST) begin
					state_q <= ST_IDLE;
				end else begin
					ch_q <= ch_q + CH_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick_en || burst_go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_en) begin
			res_q.kind            <= KIND_LINK;
			res_q.channel         <= '0;
			res_q.raw_value       <= '0;
			res_q.position_tenths <= '0;
			res_q.in_range        <= 1'b0;
			res_q.link_ok         <= seen_q && (ms_next < timeout_q);
			res_q.last            <= 1'b1;
		end else if (burst_go) begin
			res_q.kind            <= KIND_CHAN;
			res_q.channel         <= 4'(ch_q);
			res_q.raw_value       <= rd_word;
			res_q.position_tenths <= pos_out;
			res_q.in_range        <= inr;
			res_q.link_ok         <= seen_q && (ms_q < timeout_q);
			res_q.last            <= (ch_q == CH_LAST);
		end
	end

	assign res.valid           = res_valid_q;
	assign res.kind            = res_q.kind;
	assign res.channel         = res_q.channel;
	assign res.raw_value       = res_q.raw_value;
	assign res.position_tenths = res_q.position_tenths;
	assign res.in_range        = res_q.in_range;
	assign res.link_ok         = res_q.link_ok;
	assign res.last            = res_q.last;

endmodule

// ===== hw/rtl/ibusrc_frame_rx.sv =====
// byte framing: header check, checksum, channel word staging
module ibusrc_frame_rx #(
	parameter int NUM_CHANNELS = 14,
	parameter int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_en,
	input  logic                  idle_en,
	input  logic [7:0]            data_byte,
	input  logic [CH_W-1:0]       rd_idx,
	output logic                  frame_ok,
	output logic [15:0]           rd_word
);
	import ibusrc_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      sum_q;
	logic             hdr_q;
	logic [7:0]       lo_q;
	logic [15:0]      stage_q [NUM_CHANNELS];
	logic [3:0]       word_idx;
	logic             in_data;
	logic             stage_we;

	assign in_data  = (cnt_q >= IDX_DATA) && (cnt_q < IDX_CHK);
	assign word_idx = cnt_q[4:1] - 4'd1;
	assign stage_we = byte_en && in_data && cnt_q[0] && (word_idx < 4'(NUM_CHANNELS));
	assign frame_ok = byte_en && (cnt_q == IDX_LAST) && hdr_q && ({data_byte, lo_q} == sum_q);
	assign rd_word  = stage_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= SUM_INIT;
			hdr_q <= 1'b0;
		end else if (idle_en) begin
			cnt_q <= '0;
			sum_q <= SUM_INIT;
			hdr_q <= 1'b0;
		end else if (byte_en) begin
			if (cnt_q == IDX_LAST) begin
				cnt_q <= '0;
				sum_q <= SUM_INIT;
				hdr_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == '0) begin
					hdr_q <= (data_byte == HDR0);
				end else if (cnt_q == IDX_HDR1) begin
					hdr_q <= hdr_q && (data_byte == HDR1);
				end
				// checksum covers everything before the check word
				if (cnt_q < IDX_CHK) begin
					sum_q <= sum_q - {8'd0, data_byte};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en && (cnt_q >= IDX_DATA) && (cnt_q <= IDX_CHK) && !cnt_q[0]) begin
			lo_q <= data_byte;
		end
		if (stage_we) begin
			stage_q[word_idx[CH_W-1:0]] <= {data_byte, lo_q};
		end
	end

endmodule
